FILE: src/ycd_pkg.sv
package ycd_pkg;

  typedef enum logic [2:0] {
    PhInactive = 3'd0,
    PhAmbient  = 3'd1,
    PhTenMin   = 3'd2,
    PhLastMin  = 3'd3,
    PhTenSec   = 3'd4,
    PhCeleb    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CfgDailyTest = 2'd0,
    CfgWakeEn    = 2'd1,
    CfgBoostEn   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic daily_test;
    logic wake_en;
    logic boost_en;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [24:0]        elapsed;
    logic [24:0]        remaining;
    logic [13:0]        inc_year;
    logic               start;
    logic               bell;
    logic signed [7:0]  normal;
    logic signed [7:0]  user;
  } rec_t;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned SodDay     = 86400;
  localparam int unsigned SodTenSec  = 86390;
  localparam int unsigned SodLastMin = 86340;
  localparam int unsigned SodTenMin  = 85800;
  localparam int unsigned SodAmbient = 64800;
  localparam int unsigned SodCeleb   = 120;
  localparam int unsigned EveHour    = 18;
  localparam int unsigned HourMs     = 3600000;
  localparam int unsigned RampMs     = 600000;
  localparam int unsigned FadeStart  = 110000;
  localparam int unsigned FadeMs     = 10000;
  localparam int unsigned ModShift   = 21;
  localparam int unsigned DivShift   = 28;
  localparam int unsigned Year25Mul  = 5243;
  localparam int unsigned Year25Sh   = 17;

  localparam logic [13:0] ModTenMin  = 14'd15000;
  localparam logic [13:0] ModLastMin = 14'd10000;
  localparam logic [13:0] ModCeleb   = 14'd12000;
  localparam logic [7:0]  RecTenMin  = 8'((1 << ModShift) / 15000);
  localparam logic [7:0]  RecLastMin = 8'((1 << ModShift) / 10000);
  localparam logic [7:0]  RecCeleb   = 8'((1 << ModShift) / 12000);
  localparam logic [14:0] RecRamp    = 15'((1 << DivShift) / RampMs);
  localparam logic [14:0] RecFade    = 15'((1 << DivShift) / FadeMs);

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                        d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     d = 5'd30;
      default:                     d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] amb_parts(logic [2:0] idx);
    logic [3:0] p;
    case (idx)
      3'd0:    p = 4'd1;
      3'd1:    p = 4'd2;
      3'd2:    p = 4'd3;
      3'd3:    p = 4'd4;
      3'd4:    p = 4'd6;
      default: p = 4'd10;
    endcase
    return p;
  endfunction

  function automatic logic [13:0] amb_period(logic [2:0] idx);
    logic [13:0] p;
    case (idx)
      3'd0:    p = 14'd15000;
      3'd1:    p = 14'd12000;
      3'd2:    p = 14'd10000;
      3'd3:    p = 14'd8000;
      3'd4:    p = 14'd6000;
      default: p = 14'd4000;
    endcase
    return p;
  endfunction

endpackage

FILE: src/ycd_front.sv
module ycd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                daily_test_i,
  input  logic                in_push_i,
  output logic                in_full_o,
  input  logic [13:0]         year_i,
  input  logic [3:0]          month_i,
  input  logic [4:0]          day_i,
  input  logic [4:0]          hours_i,
  input  logic [5:0]          minutes_i,
  input  logic [5:0]          seconds_i,
  input  logic [9:0]          millis_i,
  input  logic signed [7:0]   normal_i,
  input  logic signed [7:0]   user_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output ycd_pkg::rec_t       q_rec_o
);
  import ycd_pkg::*;

  logic              v_q;
  logic [13:0]       year_q;
  logic [3:0]        month_q;
  logic [4:0]        day_q;
  logic [4:0]        hours_q;
  logic [9:0]        ms_q;
  logic [16:0]       sod_q;
  logic [9:0]        y25_q;
  logic signed [7:0] normal_q, user_q;
  logic [26:0]       y25_prod;

  phase_e      phase_q, phase_d;
  logic [26:0] bell_key_q, bell_key_d;
  logic [13:0] inc_year_q, inc_year_d;
  logic        fire, accept;

  assign fire      = v_q && !q_full_i;
  assign in_full_o = v_q && q_full_i;
  assign accept    = in_push_i && !in_full_o;
  assign q_push_o  = fire;
  assign y25_prod  = 27'(year_i) * 27'(Year25Mul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (accept) begin
      v_q <= 1'b1;
    end else if (fire) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      year_q   <= year_i;
      month_q  <= month_i;
      day_q    <= day_i;
      hours_q  <= hours_i;
      ms_q     <= millis_i;
      sod_q    <= 17'(hours_i) * 17'd3600 + 17'(minutes_i) * 17'd60 + 17'(seconds_i);
      y25_q    <= 10'(y25_prod >> Year25Sh);
      normal_q <= normal_i;
      user_q   <= user_i;
    end
  end

  always_comb begin
    logic        is_ye, is_nd, eve, celeb, before_mid, after_mid, div25, leap;
    logic [16:0] base;
    logic [26:0] el_full, left, rem;
    logic [14:0] ky;
    logic [3:0]  km;
    logic [4:0]  kd;
    logic [27:0] kyx, kprod;
    logic [26:0] key;

    is_ye      = (month_q == 4'd12) && (day_q == 5'd31);
    is_nd      = (month_q == 4'd1) && (day_q == 5'd1);
    eve        = daily_test_i || is_ye;
    celeb      = daily_test_i || is_nd;
    before_mid = eve && (hours_q >= 5'(EveHour));
    after_mid  = celeb && (sod_q < 17'(SodCeleb));
    div25      = ((14'(y25_q) * 14'd25) == year_q) && (y25_q < 10'd656);
    leap       = ((year_q[1:0] == 2'd0) && !div25) || ((year_q[3:0] == 4'd0) && div25);

    phase_d = PhInactive;
    base    = 17'd0;
    if (before_mid) begin
      if (sod_q >= 17'(SodTenSec)) begin
        phase_d = PhTenSec;
        base    = sod_q - 17'(SodTenSec);
      end else if (sod_q >= 17'(SodLastMin)) begin
        phase_d = PhLastMin;
        base    = sod_q - 17'(SodLastMin);
      end else if (sod_q >= 17'(SodTenMin)) begin
        phase_d = PhTenMin;
        base    = sod_q - 17'(SodTenMin);
      end else begin
        phase_d = PhAmbient;
        base    = sod_q - 17'(SodAmbient);
      end
    end else if (after_mid) begin
      phase_d = PhCeleb;
      base    = sod_q;
    end
    el_full = 27'(base) * 27'd1000 + 27'(ms_q);

    left = (sod_q < 17'(SodDay)) ? 27'(17'(SodDay) - sod_q) * 27'd1000 : 27'd0;
    rem  = (left > 27'(ms_q)) ? left - 27'(ms_q) : 27'd0;

    ky = {1'b0, year_q};
    km = month_q;
    kd = day_q;
    if (after_mid) begin
      if (day_q <= 5'd1) begin
        if (month_q <= 4'd1) begin
          km = 4'd12;
          ky = {1'b0, year_q} - 15'd1;
        end else begin
          km = month_q - 4'd1;
        end
        kd = month_days(km, leap);
      end else begin
        kd = day_q - 5'd1;
      end
    end
    kyx   = {{13{ky[14]}}, ky};
    kprod = kyx * 28'd10000 + 28'(km) * 28'd100 + 28'(kd);
    key   = daily_test_i ? kprod[26:0] : kyx[26:0];

    inc_year_d = inc_year_q;
    bell_key_d = bell_key_q;
    q_rec_o    = '0;
    if (before_mid) begin
      inc_year_d = is_ye ? year_q + 14'd1 : year_q;
    end else if (after_mid) begin
      inc_year_d = year_q;
      if ((sod_q <= 17'd1) && (bell_key_q != key)) begin
        bell_key_d   = key;
        q_rec_o.bell = 1'b1;
      end
    end
    q_rec_o.phase     = phase_d;
    q_rec_o.elapsed   = (phase_d == PhInactive) ? 25'd0 : el_full[24:0];
    q_rec_o.remaining = before_mid ? rem[24:0] : 25'd0;
    q_rec_o.inc_year  = inc_year_d;
    q_rec_o.start     = (phase_d == PhTenMin) && (phase_q != PhTenMin);
    q_rec_o.normal    = normal_q;
    q_rec_o.user      = user_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhInactive;
      bell_key_q <= '0;
      inc_year_q <= '0;
    end else if (fire) begin
      phase_q    <= phase_d;
      bell_key_q <= bell_key_d;
      inc_year_q <= inc_year_d;
    end
  end

endmodule

FILE: src/ycd_queue.sv
module ycd_queue #(
  parameter int unsigned Depth = ycd_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ycd_pkg::rec_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output ycd_pkg::rec_t rdata_o,
  output logic          empty_o
);
  import ycd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: src/ycd_back.sv
module ycd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wake_en_i,
  input  logic                boost_en_i,
  input  logic                q_empty_i,
  input  ycd_pkg::rec_t       q_rec_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [2:0]          phase_o,
  output logic [24:0]         phase_elapsed_ms_o,
  output logic [24:0]         remaining_ms_o,
  output logic [13:0]         incoming_year_o,
  output logic                countdown_start_o,
  output logic                midnight_bell_o,
  output logic                takeover_o,
  output logic                wake_o,
  output logic [3:0]          particles_o,
  output logic [13:0]         accent_period_ms_o,
  output logic signed [7:0]   brightness_o
);
  import ycd_pkg::*;

  logic        en;
  logic        s1_v_q, s2_v_q, s3_v_q;
  rec_t        s1_rec_q, s2_rec_q;
  logic [27:0] s1_xb_q, s2_xb_q;
  logic [6:0]  s1_n_q, s2_n_q;
  logic        s1_low_q, s2_low_q;
  logic [6:0]  s2_qm_q;
  logic [8:0]  s2_qb_q;

  logic [6:0]  n_d;
  logic        low_d;
  logic [27:0] xb_d;
  logic [6:0]  qm_d;
  logic [8:0]  qb_d;

  assign en      = !s3_v_q || pop_i;
  assign q_pop_o = en && !q_empty_i;
  assign empty_o = !s3_v_q;

  always_comb begin
    logic [7:0]  span;
    logic [24:0] e, f;
    logic [19:0] pf;
    n_d   = q_rec_i.normal[7] ? 7'd0 : q_rec_i.normal[6:0];
    low_d = q_rec_i.user < $signed({1'b0, n_d});
    span  = 8'(q_rec_i.user) - {1'b0, n_d};
    e     = q_rec_i.elapsed;
    if (e < 25'(FadeStart)) begin
      f = 25'd0;
    end else if (e - 25'(FadeStart) > 25'(FadeMs)) begin
      f = 25'(FadeMs);
    end else begin
      f = e - 25'(FadeStart);
    end
    if (q_rec_i.phase == PhTenMin) begin
      pf = (e > 25'(RampMs)) ? 20'(RampMs) : e[19:0];
    end else begin
      pf = f[19:0];
    end
    xb_d = (low_d ? 28'd0 : 28'(span)) * 28'(pf);
  end

  always_comb begin
    logic [7:0]  rm;
    logic [14:0] rb;
    logic [27:0] pm;
    logic [42:0] pb;
    case (s1_rec_q.phase)
      PhLastMin: rm = RecLastMin;
      PhCeleb:   rm = RecCeleb;
      default:   rm = RecTenMin;
    endcase
    rb   = (s1_rec_q.phase == PhTenMin) ? RecRamp : RecFade;
    pm   = 28'(s1_rec_q.elapsed[19:0]) * 28'(rm);
    pb   = 43'(s1_xb_q) * 43'(rb);
    qm_d = 7'(pm >> ModShift);
    qb_d = 9'(pb >> DivShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= !q_empty_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rec_q <= q_rec_i;
      s1_xb_q  <= xb_d;
      s1_n_q   <= n_d;
      s1_low_q <= low_d;
      s2_rec_q <= s1_rec_q;
      s2_xb_q  <= s1_xb_q;
      s2_n_q   <= s1_n_q;
      s2_low_q <= s1_low_q;
      s2_qm_q  <= qm_d;
      s2_qb_q  <= qb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [13:0] cm;
    logic [19:0] cb;
    logic [20:0] rmd;
    logic [28:0] rbd;
    logic [8:0]  qb;
    logic [24:0] e;
    logic [2:0]  idx;
    logic        take;
    logic [3:0]  parts;
    logic [13:0] period;
    logic [9:0]  br;
    if (en) begin
      e = s2_rec_q.elapsed;
      case (s2_rec_q.phase)
        PhLastMin: cm = ModLastMin;
        PhCeleb:   cm = ModCeleb;
        default:   cm = ModTenMin;
      endcase
      cb  = (s2_rec_q.phase == PhTenMin) ? 20'(RampMs) : 20'(FadeMs);
      rmd = 21'(e[19:0]) - 21'(s2_qm_q) * 21'(cm);
      if (rmd >= 21'(cm)) begin
        rmd = rmd - 21'(cm);
      end
      rbd = 29'(s2_xb_q) - 29'(s2_qb_q) * 29'(cb);
      qb  = (rbd >= 29'(cb)) ? s2_qb_q + 9'd1 : s2_qb_q;

      if (e >= 25'(5 * HourMs))      idx = 3'd5;
      else if (e >= 25'(4 * HourMs)) idx = 3'd4;
      else if (e >= 25'(3 * HourMs)) idx = 3'd3;
      else if (e >= 25'(2 * HourMs)) idx = 3'd2;
      else if (e >= 25'(HourMs))     idx = 3'd1;
      else                           idx = 3'd0;

      take   = 1'b0;
      parts  = 4'd0;
      period = 14'd2000;
      case (s2_rec_q.phase)
        PhAmbient: begin
          parts  = amb_parts(idx);
          period = amb_period(idx);
        end
        PhTenMin: begin
          take  = rmd >= 21'd10000;
          parts = 4'd8;
        end
        PhLastMin: begin
          take  = rmd >= 21'd5000;
          parts = 4'd8;
        end
        PhTenSec: begin
          take  = 1'b1;
          parts = 4'd12;
        end
        PhCeleb: begin
          take  = rmd < 21'd9000;
          parts = 4'd12;
        end
        default: begin
          take = 1'b0;
        end
      endcase

      br = 10'(s2_n_q);
      if (!boost_en_i) begin
        br = 10'(s2_rec_q.normal);
      end else if (!s2_low_q) begin
        case (s2_rec_q.phase)
          PhTenMin:            br = 10'(s2_n_q) + 10'(qb);
          PhLastMin, PhTenSec: br = 10'(s2_rec_q.user);
          PhCeleb: begin
            if (e < 25'(FadeStart)) begin
              br = 10'(s2_rec_q.user);
            end else begin
              br = 10'(s2_rec_q.user) - 10'(qb);
            end
          end
          default:             br = 10'(s2_n_q);
        endcase
      end

      phase_o            <= s2_rec_q.phase;
      phase_elapsed_ms_o <= e;
      remaining_ms_o     <= s2_rec_q.remaining;
      incoming_year_o    <= s2_rec_q.inc_year;
      countdown_start_o  <= s2_rec_q.start;
      midnight_bell_o    <= s2_rec_q.bell;
      takeover_o         <= take;
      wake_o             <= wake_en_i &&
                            (s2_rec_q.phase == PhTenSec || s2_rec_q.phase == PhCeleb);
      particles_o        <= parts;
      accent_period_ms_o <= period;
      brightness_o       <= br[7:0];
    end
  end

endmodule

FILE: src/year_end_countdown_sequencer_unit.sv
// Channel   Direction  Handshake           Payload
// input     in         push / full         year_i .. user_level_i
// result    out        empty / pop         phase_o .. brightness_o
// config    in         cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// One transaction is accepted per cycle while full is low; the result passes through
// the input register, the queue and three result stages before it reaches the ports.
// The front classifier and the result pipeline are split by a small queue so
// either side can stall while the other keeps going. Reset clears the valid flags,
// queue pointers and front control state and restores the configuration defaults.
module year_end_countdown_sequencer_unit #(
  parameter int unsigned QueueDepth = ycd_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic [13:0]         year_i,
  input  logic [3:0]          month_i,
  input  logic [4:0]          day_of_month_i,
  input  logic [4:0]          hours_i,
  input  logic [5:0]          minutes_i,
  input  logic [5:0]          seconds_i,
  input  logic [9:0]          millis_i,
  input  logic signed [7:0]   normal_level_i,
  input  logic signed [7:0]   user_level_i,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          phase_o,
  output logic [24:0]         phase_elapsed_ms_o,
  output logic [24:0]         remaining_ms_o,
  output logic [13:0]         incoming_year_o,
  output logic                countdown_start_o,
  output logic                midnight_bell_o,
  output logic                takeover_o,
  output logic                wake_o,
  output logic [3:0]          particles_o,
  output logic [13:0]         accent_period_ms_o,
  output logic signed [7:0]   brightness_o
);
  import ycd_pkg::*;

  cfg_t cfg_q;
  rec_t wr_rec, rd_rec;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{daily_test: 1'b0, wake_en: 1'b1, boost_en: 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDailyTest: cfg_q.daily_test <= cfg_wdata_i;
        CfgWakeEn:    cfg_q.wake_en    <= cfg_wdata_i;
        CfgBoostEn:   cfg_q.boost_en   <= cfg_wdata_i;
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  ycd_front u_front (
    .clk_i,
    .rst_ni,
    .daily_test_i (cfg_q.daily_test),
    .in_push_i    (push),
    .in_full_o    (full),
    .year_i,
    .month_i,
    .day_i        (day_of_month_i),
    .hours_i,
    .minutes_i,
    .seconds_i,
    .millis_i,
    .normal_i     (normal_level_i),
    .user_i       (user_level_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_rec_o      (wr_rec)
  );

  ycd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .wdata_i (wr_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (rd_rec),
    .empty_o (q_empty)
  );

  ycd_back u_back (
    .clk_i,
    .rst_ni,
    .wake_en_i  (cfg_q.wake_en),
    .boost_en_i (cfg_q.boost_en),
    .q_empty_i  (q_empty),
    .q_rec_i    (rd_rec),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .phase_o,
    .phase_elapsed_ms_o,
    .remaining_ms_o,
    .incoming_year_o,
    .countdown_start_o,
    .midnight_bell_o,
    .takeover_o,
    .wake_o,
    .particles_o,
    .accent_period_ms_o,
    .brightness_o
  );

endmodule
